// ===== hdl/lru_cache_hit_cost_counter_top_assert.svh =====
// Assertion macros for the LRU cache hit cost counter.
`ifndef LRU_CACHE_HIT_COST_COUNTER_TOP_ASSERT_SVH
`define LRU_CACHE_HIT_COST_COUNTER_TOP_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define LCHC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence.
`define LCHC_ASSERT_IMPLY(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lchc_pkg.sv =====
// Shared types and constants of the LRU cache hit cost counter.
`timescale 1ns / 1ps

package lchc_pkg;

   localparam int KEY_W   = 64;
   localparam int COST_W  = 4;
   localparam int TOTAL_W = 32;
   localparam int CAP_W   = 5;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [7:0] FOLD_LIMIT = 8'd97;
   localparam logic [7:0] FOLD_DELTA = 8'd32;

   localparam logic [COST_W-1:0] HIT_COST_RESET  = 4'd1;
   localparam logic [COST_W-1:0] MISS_COST_RESET = 4'd5;

   // Register index, taken from the word address.
   localparam logic [1:0] REG_CAPACITY  = 2'd0;
   localparam logic [1:0] REG_HIT_COST  = 2'd1;
   localparam logic [1:0] REG_MISS_COST = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             last_access;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [COST_W-1:0]  access_cost;
      logic [TOTAL_W-1:0] running_total;
   } rsp_type;

   typedef struct packed {
      logic update;
      logic hit;
      logic evict;
      logic insert;
   } lchc_ctrl_type;

endpackage

// ===== hdl/lru_cache_hit_cost_counter_top.sv =====
// Top level of the LRU cache hit cost counter.
`timescale 1ns / 1ps
`include "lru_cache_hit_cost_counter_top_assert.svh"

// Fully associative LRU cache that charges a cost per access and keeps a total.
// A transaction is taken when start is high and busy is low; req_data holds the
// key and the last-access mark. The key is case folded byte by byte, then compared
// against every entry at once in a row of cells ordered from least to most recent.
// A transaction first registers the folded key, then does the parallel compare
// and the one-step shift of the cell row while busy is high, so no new
// transaction is taken until the current one is through the compare.
// The result sits on rsp_data with rsp_valid high for exactly one cycle, the cycle
// after the compare, and the receiver cannot stall it.
// After a last-access transaction the cache and total are empty again.
// Synchronous reset empties the cache, clears the total and sets capacity to 0,
// hit cost to 1 and miss cost to 5. Registers sit on an APB port at 0, 4 and 8;
// the user must write them only while the block is idle; the block does not enforce this.
module lru_cache_hit_cost_counter_top #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BYTES   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lchc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output lchc_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lchc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lchc_pkg::DATA_W-1:0]   pwdata,
   output logic [lchc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import lchc_pkg::*;

   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

   logic [CAP_W-1:0]   cap_ff;
   logic [COST_W-1:0]  hit_cost_ff;
   logic [COST_W-1:0]  miss_cost_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic               last_ff;
   logic               busy_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   logic               csr_write;
   logic [OCC_W-1:0]   cap_eff;
   logic               found;
   logic               evict;
   logic [OCC_W-1:0]   wr_idx;
   logic [COST_W-1:0]  cost;
   logic [TOTAL_W:0]   total_sum;
   lchc_ctrl_type      ctrl;

   logic [KEY_W-1:0]   tag_chain [MAX_ENTRIES:0];
   logic               seen_chain [MAX_ENTRIES:0];

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         hit_cost_ff  <= HIT_COST_RESET;
         miss_cost_ff <= MISS_COST_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_CAPACITY:  cap_ff       <= pwdata[CAP_W-1:0];
            REG_HIT_COST:  hit_cost_ff  <= pwdata[COST_W-1:0];
            REG_MISS_COST: miss_cost_ff <= pwdata[COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_CAPACITY:  prdata = DATA_W'(cap_ff);
         REG_HIT_COST:  prdata = DATA_W'(hit_cost_ff);
         REG_MISS_COST: prdata = DATA_W'(miss_cost_ff);
         default:       prdata = '0;
      endcase
   end

   // Case fold: bytes of 97 or more lose 32; bytes past the key length read as zero.
   for (genvar b = 0; b < 8; b++) begin : g_fold
      if (b < KEY_BYTES) begin : g_used
         logic [7:0] raw_byte;
         assign raw_byte = req_data.key[8*b +: 8];
         assign key_in[8*b +: 8] = (raw_byte >= FOLD_LIMIT) ? (raw_byte - FOLD_DELTA)
                                                             : raw_byte;
      end else begin : g_unused
         assign key_in[8*b +: 8] = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= key_in;
         last_ff <= req_data.last_access;
      end
   end

   // Capacity above the number of cells acts as a full row.
   assign cap_eff = ({3'b000, cap_ff} > 8'(MAX_ENTRIES)) ? OCC_W'(MAX_ENTRIES)
                                                         : OCC_W'(cap_ff);

   assign found = seen_chain[MAX_ENTRIES];
   assign evict = !found && (occ_ff != '0) && (occ_ff >= cap_eff);

   always_comb begin
      ctrl.update = busy_ff;
      ctrl.hit    = found;
      ctrl.evict  = evict;
      ctrl.insert = found || ((cap_eff != '0) && (evict || (occ_ff < OCC_W'(MAX_ENTRIES))));
   end

   // A hit or an eviction frees the top slot, so the new tag goes one below the fill.
   assign wr_idx = (found || evict) ? (occ_ff - OCC_W'(1)) : occ_ff;

   assign tag_chain[MAX_ENTRIES] = key_ff;
   assign seen_chain[0]          = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lchc_cell #(
         .IDX   (i),
         .OCC_W (OCC_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .occ      (occ_ff),
         .wr_idx   (wr_idx),
         .key_tag  (key_ff),
         .next_tag (tag_chain[i+1]),
         .seen_in  (seen_chain[i]),
         .seen_out (seen_chain[i+1]),
         .tag_out  (tag_chain[i])
      );
   end

   assign cost      = found ? hit_cost_ff : miss_cost_ff;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(cost);

   always_comb begin
      rsp_data_in.hit           = found;
      rsp_data_in.access_cost   = cost;
      rsp_data_in.running_total = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                     : total_sum[TOTAL_W-1:0];
   end

   always_comb begin
      occ_in   = occ_ff;
      total_in = total_ff;
      if (busy_ff) begin
         if (last_ff) begin
            occ_in   = '0;
            total_in = '0;
         end else begin
            total_in = rsp_data_in.running_total;
            if (!found) begin
               occ_in = occ_ff + OCC_W'(ctrl.insert) - OCC_W'(evict);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         occ_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= accept;
         occ_ff       <= occ_in;
         total_ff     <= total_in;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LCHC_ASSERT_ALWAYS(a_occ_bound, occ_ff <= OCC_W'(MAX_ENTRIES), "occupancy above cell count")
   `LCHC_ASSERT_IMPLY(a_latency, accept, ##2 rsp_valid, "result missing two cycles after accept")
   `LCHC_ASSERT_IMPLY(a_last_clears, busy_ff && last_ff, ##1 (occ_ff == '0 && total_ff == '0),
      "last access did not clear state")

endmodule

// ===== hdl/lchc_cell.sv =====
// One cache entry: stores a tag, compares it and shifts toward the LRU end.
`timescale 1ns / 1ps

module lchc_cell #(
   parameter int IDX   = 0,
   parameter int OCC_W = 5
) (
   input  logic                      clock,
   input  lchc_pkg::lchc_ctrl_type   ctrl,
   input  logic [OCC_W-1:0]          occ,
   input  logic [OCC_W-1:0]          wr_idx,
   input  logic [lchc_pkg::KEY_W-1:0] key_tag,
   input  logic [lchc_pkg::KEY_W-1:0] next_tag,
   input  logic                      seen_in,
   output logic                      seen_out,
   output logic [lchc_pkg::KEY_W-1:0] tag_out
);
   import lchc_pkg::*;

   logic [KEY_W-1:0] tag_ff;
   logic [KEY_W-1:0] tag_in;
   logic             valid;
   logic             shift;

   assign valid    = OCC_W'(IDX) < occ;
   assign seen_out = seen_in | (valid && (tag_ff == key_tag));
   assign tag_out  = tag_ff;

   // On a hit only the entries from the match upward move down; an eviction moves all.
   assign shift = ctrl.hit ? seen_out : ctrl.evict;

   always_comb begin
      tag_in = tag_ff;
      if (ctrl.update) begin
         if (ctrl.insert && (OCC_W'(IDX) == wr_idx)) begin
            tag_in = key_tag;
         end else if (shift) begin
            tag_in = next_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

endmodule

// ===== tb/lchc_checker.sv =====
// Checker that predicts each cache access result and compares it with the block's output.
`timescale 1ns / 1ps

module lchc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  lchc_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  lchc_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lchc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lchc_pkg::DATA_W-1:0]   pwdata,
   input  logic [lchc_pkg::DATA_W-1:0]   prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            pending_count,
   output int                            access_count,
   output int                            hit_count
);
   import lchc_pkg::*;

   localparam int CACHE_DEPTH = 16;

   // Tags are kept from least recent at index 0 to most recent at occupied-1.
   logic [KEY_W-1:0]   lru_tags [CACHE_DEPTH];
   int                 occupied;
   logic [TOTAL_W-1:0] cost_sum;
   logic [CAP_W-1:0]   capacity_reg;
   logic [COST_W-1:0]  hit_cost_reg;
   logic [COST_W-1:0]  miss_cost_reg;
   rsp_type            expected_rsps [$];
   int                 mismatches = 0;
   int                 checked = 0;
   int                 hits_seen = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] cache mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [KEY_W-1:0] case_fold(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] folded;
      logic [7:0]       b;
      folded = raw;
      for (int i = 0; i < KEY_W / 8; i++) begin
         b = raw[8*i +: 8];
         if (b >= FOLD_LIMIT) begin
            folded[8*i +: 8] = b - FOLD_DELTA;
         end
      end
      return folded;
   endfunction

   task automatic drop_entry(input int pos);
      for (int i = pos; i + 1 < occupied; i++) begin
         lru_tags[i] = lru_tags[i + 1];
      end
      if (occupied > 0) begin
         occupied--;
      end
   endtask

   task automatic predict_access(input req_type item);
      logic [KEY_W-1:0]  tag;
      logic [COST_W-1:0] cost;
      logic              found;
      int                limit;
      int                pos;
      rsp_type           rsp;
      tag   = case_fold(item.key);
      limit = (capacity_reg > CACHE_DEPTH) ? CACHE_DEPTH : int'(capacity_reg);
      found = 1'b0;
      pos   = 0;
      for (int i = 0; i < occupied; i++) begin
         if (!found && lru_tags[i] == tag) begin
            found = 1'b1;
            pos   = i;
         end
      end
      if (found) begin
         cost = hit_cost_reg;
         drop_entry(pos);
         if (occupied < CACHE_DEPTH) begin
            lru_tags[occupied] = tag;
            occupied++;
         end
      end else begin
         cost = miss_cost_reg;
         // A lowered capacity still costs only one eviction per miss.
         if (occupied > 0 && occupied >= limit) begin
            drop_entry(0);
         end
         if (limit != 0 && occupied < CACHE_DEPTH) begin
            lru_tags[occupied] = tag;
            occupied++;
         end
      end
      if (cost_sum > {TOTAL_W{1'b1}} - cost) begin
         cost_sum = '1;
      end else begin
         cost_sum = cost_sum + cost;
      end
      rsp.hit           = found;
      rsp.access_cost   = cost;
      rsp.running_total = cost_sum;
      expected_rsps.insert(expected_rsps.size(), rsp);
      if (item.last_access) begin
         occupied = 0;
         cost_sum = '0;
      end
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("result with no access pending (hit=%0b cost=%0d total=%0d)",
                                   got.hit, got.access_cost, got.running_total));
         return;
      end
      want = expected_rsps[0];
      expected_rsps.delete(0);
      checked++;
      if (want.hit) begin
         hits_seen++;
      end
      if (got.hit !== want.hit) begin
         report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      end
      if (got.access_cost !== want.access_cost) begin
         report_mismatch($sformatf("access_cost %0d, expected %0d",
                                   got.access_cost, want.access_cost));
      end
      if (got.running_total !== want.running_total) begin
         report_mismatch($sformatf("running_total %0d, expected %0d",
                                   got.running_total, want.running_total));
      end
   endtask

   function automatic logic [DATA_W-1:0] register_value(input logic [1:0] index);
      case (index)
         REG_CAPACITY:  return {{(DATA_W - CAP_W){1'b0}}, capacity_reg};
         REG_HIT_COST:  return {{(DATA_W - COST_W){1'b0}}, hit_cost_reg};
         REG_MISS_COST: return {{(DATA_W - COST_W){1'b0}}, miss_cost_reg};
         default:       return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         occupied      = 0;
         cost_sum      = '0;
         capacity_reg  = '0;
         hit_cost_reg  = HIT_COST_RESET;
         miss_cost_reg = MISS_COST_RESET;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            compare_result(rsp_data);
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[ADDR_W-1:2])
                  REG_CAPACITY:  capacity_reg  = pwdata[CAP_W-1:0];
                  REG_HIT_COST:  hit_cost_reg  = pwdata[COST_W-1:0];
                  REG_MISS_COST: miss_cost_reg = pwdata[COST_W-1:0];
                  default: ;
               endcase
            end else if (prdata !== register_value(paddr[ADDR_W-1:2])) begin
               report_mismatch($sformatf("register at 0x%0h reads 0x%0h, expected 0x%0h",
                                         paddr, prdata, register_value(paddr[ADDR_W-1:2])));
            end
         end
         if (start && !busy) begin
            predict_access(req_data);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_rsps.size();
      access_count  <= checked;
      hit_count     <= hits_seen;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, cache access and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_top;
   import lchc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 105;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   req_type             req_data = '0;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic                busy;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  pending_count;
   int                  access_count;
   int                  hit_count;
   int                  stalled_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lru_cache_hit_cost_counter_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   lchc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .access_count  (access_count),
      .hit_count     (hit_count)
   );

   // Any accepted transaction on either channel or the register port restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transaction.", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   task automatic issue_access(input logic [KEY_W-1:0] key, input logic last,
                               input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= req_type'{key: key, last_access: last};
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_access(input logic [1:0] index, input logic write,
                             input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic read_registers();
      csr_access(REG_CAPACITY, 1'b0, '0);
      csr_access(REG_HIT_COST, 1'b0, '0);
      csr_access(REG_MISS_COST, 1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_registers(input int capacity, input int hit_cost, input int miss_cost);
      csr_access(REG_CAPACITY, 1'b1, DATA_W'(capacity));
      csr_access(REG_HIT_COST, 1'b1, DATA_W'(hit_cost));
      csr_access(REG_MISS_COST, 1'b1, DATA_W'(miss_cost));
      read_registers();
   endtask

   // Keys of random length, biased toward the letter range so case folding matters.
   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] key;
      int               len;
      key = '0;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 1) == 1) begin
            key[8*i +: 8] = 8'($urandom_range(64, 130));
         end else begin
            key[8*i +: 8] = 8'($urandom_range(0, 255));
         end
      end
      return key;
   endfunction

   // Bytes 65 to 96 and the bytes 32 above them fold to the same value, so swapping
   // within such a pair gives a different raw key that must still hit.
   function automatic logic [KEY_W-1:0] swap_case(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] varied;
      logic [7:0]       b;
      varied = key;
      for (int i = 0; i < KEY_W / 8; i++) begin
         b = key[8*i +: 8];
         if ($urandom_range(0, 1) == 1) begin
            if (b >= 8'd65 && b <= 8'd96) begin
               varied[8*i +: 8] = b + 8'd32;
            end else if (b >= 8'd97 && b <= 8'd128) begin
               varied[8*i +: 8] = b - 8'd32;
            end
         end
      end
      return varied;
   endfunction

   task automatic run_random_phase(input int items, input int idle_pct);
      logic [KEY_W-1:0] key_pool [$];
      logic [KEY_W-1:0] key;
      int               pool_size;
      pool_size = $urandom_range(2, 20);
      repeat (pool_size) key_pool.insert(key_pool.size(), random_key());
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < 80) begin
            key = swap_case(key_pool[$urandom_range(0, pool_size - 1)]);
         end else if ($urandom_range(0, 3) == 0) begin
            key = {$urandom, $urandom};
         end else begin
            key = random_key();
         end
         issue_access(key, $urandom_range(0, 39) == 0, idle_pct);
      end
   endtask

   initial begin
      int idle_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset values: capacity zero, so repeated keys still miss.
      issue_access(64'h0, 1'b0, 0);
      issue_access(64'h0, 1'b0, 0);
      drain_results();
      read_registers();

      set_registers(4, 3, 7);
      issue_access(64'h61, 1'b0, 0);
      issue_access(64'h41, 1'b0, 0);
      issue_access(64'h60, 1'b0, 0);
      // A byte of 128 folds onto 96, which itself is left alone.
      issue_access(64'h80, 1'b0, 0);
      issue_access(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
      issue_access(64'hDFDF_DFDF_DFDF_DFDF, 1'b0, 0);
      issue_access(64'h0, 1'b0, 0);
      issue_access(64'h1, 1'b0, 0);
      issue_access(64'h41, 1'b0, 0);
      issue_access(64'hDFDF_DFDF_DFDF_DFDF, 1'b0, 0);
      issue_access(64'h6867_6665_6463_6261, 1'b1, 0);
      issue_access(64'h41, 1'b0, 0);
      issue_access(64'h1, 1'b0, 0);
      issue_access(64'h2, 1'b0, 0);
      issue_access(64'h3, 1'b0, 0);
      drain_results();

      // Capacity lowered under a full cache, then turned off entirely.
      set_registers(1, 0, 15);
      issue_access(64'h5, 1'b0, 0);
      drain_results();
      set_registers(0, 15, 0);
      issue_access(64'h6, 1'b0, 0);
      issue_access(64'h3, 1'b0, 0);
      issue_access(64'h2, 1'b1, 0);

      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: begin set_registers(16, 15, 0);  idle_pct = 28; end
            1: begin set_registers(2, 0, 15);   idle_pct = 28; end
            2: begin set_registers(31, 7, 9);   idle_pct = 88; end
            3: begin set_registers(0, 15, 15);  idle_pct = 88; end
            4: begin set_registers(1, 3, 0);    idle_pct = 0;  end
            default: begin
               set_registers($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 15));
               idle_pct = 0;
            end
         endcase
         run_random_phase(PHASE_ITEMS, idle_pct);
      end
      drain_results();
      repeat (4) @(posedge clock);

      $display("Checked %0d cache accesses, %0d of them hits.", access_count, hit_count);
      $display("Capacities ran from 0 to 31 and both costs from 0 to 15, with and without gaps.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
